### hw/rtl/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg
// Shared request/result types and codes for the multi-stack slot pool.
// ----------------------------------------------------------------------------
package msp_pkg;

    // request kinds
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // completion status
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // one request
    typedef struct packed {
        logic               req_type;
        logic [1:0]         stack_sel;
        logic signed [31:0] push_data;
    } req_t;

    // one result
    typedef struct packed {
        status_t            status;
        logic signed [31:0] pop_data;
        logic               pool_full;
        logic               stack_empty;
    } rsp_t;

endpackage

### hw/rtl/multi_stack_shared_pool.sv
// ----------------------------------------------------------------------------
// multi_stack_shared_pool
// Several LIFO stacks chained through one shared slot pool with a free list.
// ----------------------------------------------------------------------------
// Usage:
//   A request (push or pop on one stack) is taken at a rising edge with
//   start high and busy low. Its result appears on result with done high
//   for exactly one cycle; the receiver cannot hold it off.
// Timing:
//   Accept edge: the slot address (free head for push, stack top for pop)
//   goes to the link and value RAMs. Next cycle (busy high) the read data
//   comes back and the read-modify-write of the link RAM, the head
//   registers and the free head completes. The result is registered and
//   shows in the cycle after, while the next request may already be taken.
//   A new request is taken only once the work cycle is over, as the RAM
//   read is followed by the link write-back.
// Reset:
//   All stacks empty, free head at slot 0. The link RAM is not cleared:
//   a fill count marks slots never linked, which read as "next slot", so
//   there is no clearing pass and requests are taken right after reset.
//   Value RAM contents are undefined until pushed.
// ----------------------------------------------------------------------------
module multi_stack_shared_pool
    import msp_pkg::*;
#(
    parameter int POOL_SLOTS = 64,
    parameter int NUM_STACKS = 4,
    parameter int DATA_BITS  = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t request,
    output logic done,
    output rsp_t result
);

    localparam int LINK_W = $clog2(POOL_SLOTS + 1);
    localparam int IDX_W  = $clog2(POOL_SLOTS);
    localparam int SEL_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_SLOTS);

    // fold a 2-bit stack select into range
    function automatic logic [SEL_W-1:0] wrap_sel(input logic [1:0] raw);
        int v;
        v = int'(raw);
        for (int k = 0; k < 3; k++)
        begin
            if (v >= NUM_STACKS)
            begin
                v = v - NUM_STACKS;
            end
        end
        return SEL_W'(v);
    endfunction

    // memories
    logic [LINK_W-1:0]    link_mem  [POOL_SLOTS];
    logic [DATA_BITS-1:0] value_mem [POOL_SLOTS];
    logic [LINK_W-1:0]    link_q;
    logic [DATA_BITS-1:0] value_q;

    // control state
    logic [LINK_W-1:0] head_reg [NUM_STACKS];
    logic [LINK_W-1:0] free_head_reg, free_head_next;
    logic [LINK_W-1:0] fill_reg, fill_next;
    logic              busy_reg;
    logic              done_reg;

    // captured request
    logic              req_reg;
    logic [SEL_W-1:0]  sel_reg;
    logic [31:0]       data_reg;
    logic [LINK_W-1:0] slot_reg;
    rsp_t              result_reg, result_next;

    // accept side
    logic              accept;
    logic [SEL_W-1:0]  sel_in;
    logic [LINK_W-1:0] slot_in;

    assign accept  = start && !busy_reg;
    assign sel_in  = wrap_sel(request.stack_sel);
    assign slot_in = (request.req_type == REQ_PUSH) ? free_head_reg : head_reg[sel_in];

    // work cycle: read-modify-write
    logic                 slot_ok;
    logic [LINK_W-1:0]    link_rd;
    logic                 link_we;
    logic [LINK_W-1:0]    link_wd;
    logic                 value_we;
    logic [DATA_BITS-1:0] value_wd;
    logic                 head_we;
    logic [LINK_W-1:0]    head_wd;
    logic [LINK_W-1:0]    head_after;
    logic [63:0]          data_wide;
    logic [63+DATA_BITS:0] pop_ext;

    assign slot_ok   = slot_reg < NULL_LINK;
    // never-linked slots still hold their reset chain
    assign link_rd   = (slot_reg >= fill_reg) ? (slot_reg + LINK_W'(1)) : link_q;
    assign data_wide = {32'b0, data_reg};
    assign value_wd  = data_wide[DATA_BITS-1:0];
    assign pop_ext   = {{64{value_q[DATA_BITS-1]}}, value_q};

    always_comb
    begin
        free_head_next = free_head_reg;
        fill_next      = fill_reg;
        link_we        = 1'b0;
        link_wd        = free_head_reg;
        value_we       = 1'b0;
        head_we        = 1'b0;
        head_wd        = link_rd;
        head_after     = head_reg[sel_reg];
        result_next    = '0;
        result_next.status = ST_DONE;
        if (req_reg == REQ_PUSH)
        begin
            if (slot_ok)
            begin
                free_head_next = link_rd;
                link_we        = busy_reg;
                link_wd        = head_reg[sel_reg];
                value_we       = busy_reg;
                head_we        = busy_reg;
                head_wd        = slot_reg;
                head_after     = slot_reg;
                if (slot_reg == fill_reg)
                begin
                    fill_next = fill_reg + LINK_W'(1);
                end
            end
            else
            begin
                result_next.status = ST_FULL;
            end
        end
        else
        begin
            if (slot_ok)
            begin
                free_head_next       = slot_reg;
                link_we              = busy_reg;
                link_wd              = free_head_reg;
                head_we              = busy_reg;
                head_wd              = link_rd;
                head_after           = link_rd;
                result_next.pop_data = pop_ext[31:0];
            end
            else
            begin
                result_next.status = ST_EMPTY;
            end
        end
        result_next.pool_full   = free_head_next >= NULL_LINK;
        result_next.stack_empty = head_after >= NULL_LINK;
    end

    // link and value RAMs
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            link_q  <= link_mem[slot_in[IDX_W-1:0]];
            value_q <= value_mem[slot_in[IDX_W-1:0]];
        end
        if (link_we)
        begin
            link_mem[slot_reg[IDX_W-1:0]] <= link_wd;
        end
        if (value_we)
        begin
            value_mem[slot_reg[IDX_W-1:0]] <= value_wd;
        end
    end

    // captured request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg  <= request.req_type;
            sel_reg  <= sel_in;
            data_reg <= request.push_data;
            slot_reg <= slot_in;
        end
        if (busy_reg)
        begin
            result_reg <= result_next;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            done_reg      <= 1'b0;
            free_head_reg <= '0;
            fill_reg      <= '0;
            for (int i = 0; i < NUM_STACKS; i++)
            begin
                head_reg[i] <= NULL_LINK;
            end
        end
        else
        begin
            busy_reg <= accept;
            done_reg <= busy_reg;
            if (busy_reg)
            begin
                free_head_reg <= free_head_next;
                fill_reg      <= fill_next;
            end
            if (head_we)
            begin
                head_reg[sel_reg] <= head_wd;
            end
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTH
    // every accepted request yields its result after its work cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> ##1 done)
        else $error("missing result after request");

    // a result never overlaps the work cycle
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown during work cycle");

    // fill count and free head stay within the pool
    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= NULL_LINK && free_head_reg <= NULL_LINK)
        else $error("free list pointer out of range");

    // a full-pool refusal reports the pool as full
    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == ST_FULL |-> result.pool_full)
        else $error("full status without full flag");
`endif

endmodule

### dv/tb_multi_stack_shared_pool.sv
// ----------------------------------------------------------------------------
// tb_multi_stack_shared_pool
// Self-checking bench for the shared-pool stack block. Push and pop requests
// go to all four stacks. A behavioral copy of the slot pool, the per-stack
// heads and the free chain predicts each result, and every result is checked
// field by field in order. The run fills the pool to overflow, drains every
// stack past empty, and mixes random traffic under three sender idle levels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_multi_stack_shared_pool;

    import msp_pkg::*;

    localparam int POOL_SLOTS  = 64;
    localparam int NUM_STACKS  = 4;
    localparam int DATA_BITS   = 32;
    localparam int NO_SLOT     = POOL_SLOTS;
    localparam int CYCLE_LIMIT = 200000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t request;
    logic done;
    rsp_t result;

    // behavioral pool: values, next links, stack tops and free chain head
    logic [31:0] slot_data [POOL_SLOTS];
    int          slot_next [POOL_SLOTS];
    int          stack_top [NUM_STACKS];
    int          free_top;

    rsp_t        pending_rsp_q[$];
    int          idle_pct;
    int          error_count;
    int          cycle_count;
    int          request_count;
    int          push_ok_count;
    int          pop_ok_count;
    int          full_count;
    int          empty_count;

    multi_stack_shared_pool #(
        .POOL_SLOTS (POOL_SLOTS),
        .NUM_STACKS (NUM_STACKS),
        .DATA_BITS  (DATA_BITS)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    // 12 ns clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_rsp_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // apply one request to the pool copy and return the result it gives
    function automatic rsp_t apply_request(req_t r);
        rsp_t rsp;
        int   sel;
        int   s;
        sel          = int'(r.stack_sel) % NUM_STACKS;
        rsp.status   = ST_DONE;
        rsp.pop_data = '0;
        if (r.req_type == REQ_PUSH)
        begin
            s = free_top;
            if (s >= POOL_SLOTS)
            begin
                rsp.status = ST_FULL;
                full_count++;
            end
            else
            begin
                free_top       = slot_next[s];
                slot_next[s]   = stack_top[sel];
                stack_top[sel] = s;
                slot_data[s]   = r.push_data;
                push_ok_count++;
            end
        end
        else
        begin
            s = stack_top[sel];
            if (s >= POOL_SLOTS)
            begin
                rsp.status = ST_EMPTY;
                empty_count++;
            end
            else
            begin
                stack_top[sel] = slot_next[s];
                slot_next[s]   = free_top;
                free_top       = s;
                rsp.pop_data   = slot_data[s];
                pop_ok_count++;
            end
        end
        rsp.pool_full   = (free_top >= POOL_SLOTS);
        rsp.stack_empty = (stack_top[sel] >= POOL_SLOTS);
        return rsp;
    endfunction

    function automatic req_t make_req(logic kind, int sel, logic [31:0] value);
        req_t r;
        r.req_type  = kind;
        r.stack_sel = sel[1:0];
        r.push_data = value;
        return r;
    endfunction

    // random data with the sign and range corners mixed in
    function automatic logic [31:0] rand_value();
        unique case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // drive one request, wait for it to be taken, then idle on a share of cycles
    task automatic send_request(req_t r);
        start   <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
        pending_rsp_q.push_back(apply_request(r));
        request_count++;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // hold off the sender until every result is back
    task automatic idle_until_drained();
        start <= 1'b0;
        while (pending_rsp_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin : check_results
        rsp_t want;
        if (rst_n && done)
        begin
            if (pending_rsp_q.size() == 0)
            begin
                $error("unexpected result: status %0d pop_data %h", result.status,
                       result.pop_data);
                error_count++;
            end
            else
            begin
                want = pending_rsp_q.pop_front();
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, result.status);
                    error_count++;
                end
                if (result.pop_data !== want.pop_data)
                begin
                    $error("pop_data: expected %h, got %h", want.pop_data,
                           result.pop_data);
                    error_count++;
                end
                if (result.pool_full !== want.pool_full)
                begin
                    $error("pool_full: expected %0b, got %0b", want.pool_full,
                           result.pool_full);
                    error_count++;
                end
                if (result.stack_empty !== want.stack_empty)
                begin
                    $error("stack_empty: expected %0b, got %0b", want.stack_empty,
                           result.stack_empty);
                    error_count++;
                end
            end
        end
    end

    // corners: empty pops, data extremes, alternating bit patterns, LIFO order
    task automatic test_directed();
        for (int i = 0; i < NUM_STACKS; i++)
            send_request(make_req(REQ_POP, i, 32'h0));
        send_request(make_req(REQ_PUSH, 0, 32'h8000_0000));
        send_request(make_req(REQ_PUSH, 1, 32'h7fff_ffff));
        send_request(make_req(REQ_PUSH, 2, 32'h0000_0000));
        send_request(make_req(REQ_PUSH, 3, 32'hffff_ffff));
        send_request(make_req(REQ_PUSH, 0, 32'h5555_5555));
        send_request(make_req(REQ_PUSH, 0, 32'haaaa_aaaa));
        repeat (4) send_request(make_req(REQ_POP, 0, 32'h0));
        for (int i = 1; i < NUM_STACKS; i++)
            send_request(make_req(REQ_POP, i, 32'h0));
        // pop ignores push_data
        send_request(make_req(REQ_POP, 3, 32'hdead_beef));
    endtask

    // random pushes and pops on random stacks
    task automatic test_random_mix(int count, int push_pct);
        logic kind;
        for (int n = 0; n < count; n++)
        begin
            kind = ($urandom_range(99) < push_pct) ? REQ_PUSH : REQ_POP;
            send_request(make_req(kind, $urandom_range(NUM_STACKS - 1), rand_value()));
        end
    endtask

    // fill the pool past full, then drain all stacks past empty
    task automatic test_fill_and_drain();
        int  sel;
        while (free_top < POOL_SLOTS)
            send_request(make_req(REQ_PUSH, $urandom_range(NUM_STACKS - 1), rand_value()));
        repeat (3)
            send_request(make_req(REQ_PUSH, $urandom_range(NUM_STACKS - 1), rand_value()));
        while (free_top != NO_SLOT || stack_top[0] != NO_SLOT || stack_top[1] != NO_SLOT
               || stack_top[2] != NO_SLOT || stack_top[3] != NO_SLOT)
        begin
            sel = $urandom_range(NUM_STACKS - 1);
            // mostly pick a stack that still holds data
            if ($urandom_range(9) != 0)
                for (int k = 0; k < NUM_STACKS && stack_top[sel] == NO_SLOT; k++)
                    sel = (sel + 1) % NUM_STACKS;
            send_request(make_req(REQ_POP, sel, rand_value()));
            if (stack_top[0] == NO_SLOT && stack_top[1] == NO_SLOT
                && stack_top[2] == NO_SLOT && stack_top[3] == NO_SLOT)
                break;
        end
        for (int i = 0; i < NUM_STACKS; i++)
            send_request(make_req(REQ_POP, i, rand_value()));
    endtask

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        request       = '0;
        idle_pct      = 0;
        error_count   = 0;
        cycle_count   = 0;
        request_count = 0;
        push_ok_count = 0;
        pop_ok_count  = 0;
        full_count    = 0;
        empty_count   = 0;
        for (int i = 0; i < POOL_SLOTS; i++)
        begin
            slot_data[i] = '0;
            slot_next[i] = i + 1;
        end
        for (int i = 0; i < NUM_STACKS; i++)
            stack_top[i] = NO_SLOT;
        free_top = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles now and then
        idle_pct = 23;
        test_directed();
        test_random_mix(80, 60);
        test_fill_and_drain();
        idle_until_drained();

        // sender idles most of the time
        idle_pct = 77;
        test_random_mix(80, 55);
        idle_until_drained();

        // back to back
        idle_pct = 0;
        test_random_mix(60, 50);
        test_fill_and_drain();
        idle_until_drained();

        $display("Ran %0d requests in %0d cycles: %0d pushes, %0d pops accepted,",
                 request_count, cycle_count, push_ok_count, pop_ok_count);
        $display("%0d pushes refused on a full pool, %0d pops refused on an empty stack",
                 full_count, empty_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
